// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files that check themselves (used by the top-level unit).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that one condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) else $error(msg);

`endif

// ----- rtl/paq_pkg.sv -----
package paq_pkg;

    // Width of the stored sequence number.
    localparam int SEQ_BITS = 32;

    // Configuration register indexes.
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_FOCUS    = 1'b1;

    // Operation codes on the input stream.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // Controller states, one-hot.
    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_DECIDE   = 11'b000_0000_0010,
        ST_TAKE_OUT = 11'b000_0000_0100,
        ST_DUP_CHK  = 11'b000_0000_1000,
        ST_CMP_RD   = 11'b000_0001_0000,
        ST_CMP_WR   = 11'b000_0010_0000,
        ST_EV_CHK   = 11'b000_0100_0000,
        ST_EV_RD    = 11'b000_1000_0000,
        ST_EV_TST   = 11'b001_0000_0000,
        ST_SH_RD    = 11'b010_0000_0000,
        ST_SH_WR    = 11'b100_0000_0000
    } state_t;

    // Which slot the memory read port addresses.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_HEAD,
        RD_LAST,
        RD_SCAN
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_in;
        rd_sel_t rd_sel;
        logic    scan_clr;
        logic    wr_cmp;
        logic    wr_shift;
        logic    compact_done;
        logic    head_pop;
        logic    count_dec;
        logic    store;
        logic    out_found;
        logic    out_empty;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_take;
        logic count_zero;
        logic drop;
        logic dup;
        logic item_prio;
        logic rd_prio;
        logic r_end;
        logic full;
        logic out_busy;
    } sts_t;

endpackage

// ----- rtl/paq_datapath.sv -----
module paq_datapath import paq_pkg::*; #(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  cmd_t                             cmd,
    output sts_t                             sts,
    input  logic                             in_op,
    input  logic [4*TAG_BITS+8:0]            in_item,
    input  logic [4:0]                       capacity,
    input  logic [2:0]                       focus_kind,
    input  logic                             m_tready,
    output logic                             m_valid,
    output logic                             m_found,
    output logic [4*TAG_BITS+8+SEQ_BITS:0]   m_rec,
    output logic [$clog2(DEPTH+1)-1:0]       occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MD = 1 << AW;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > 5) ? CW : 5;
    localparam int T  = TAG_BITS;
    localparam int IW = 4 * T + 9;
    localparam int RW = IW + SEQ_BITS;

    logic [RW-1:0]       mem_reg [MD];
    logic [RW-1:0]       rd_q_reg;
    logic [IW-1:0]       item_reg;
    logic                op_reg;
    logic [AW-1:0]       head_reg;
    logic [CW-1:0]       count_reg;
    logic [SEQ_BITS-1:0] seq_reg;
    logic [CW-1:0]       r_reg;
    logic [CW-1:0]       w_reg;
    logic                m_valid_reg;
    logic                m_found_reg;
    logic [RW-1:0]       m_rec_reg;

    logic [AW-1:0] tail_addr, last_addr, scan_addr, cmpw_addr, shw_addr;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [RW-1:0] wr_data;
    logic [KW-1:0] cap_ext, cap_eff;

    // Slot addresses relative to the circular head.
    assign tail_addr = head_reg + count_reg[AW-1:0];
    assign last_addr = tail_addr - AW'(1);
    assign scan_addr = head_reg + r_reg[AW-1:0];
    assign cmpw_addr = head_reg + w_reg[AW-1:0];
    assign shw_addr  = scan_addr - AW'(2);

    // Read port address selection.
    always_comb begin
        case (cmd.rd_sel)
            RD_HEAD: rd_addr = head_reg;
            RD_LAST: rd_addr = last_addr;
            RD_SCAN: rd_addr = scan_addr;
            default: rd_addr = head_reg;
        endcase
    end

    // Write port: compaction copy, shift copy or a new record at the tail.
    always_comb begin
        wr_en   = cmd.wr_cmp | cmd.wr_shift | cmd.store;
        wr_addr = tail_addr;
        wr_data = {seq_reg, item_reg};
        if (cmd.wr_cmp) begin
            wr_addr = cmpw_addr;
            wr_data = rd_q_reg;
        end else if (cmd.wr_shift) begin
            wr_addr = shw_addr;
            wr_data = rd_q_reg;
        end
    end

    // Record memory with registered read data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (cmd.rd_sel != RD_NONE) begin
            rd_q_reg <= mem_reg[rd_addr];
        end
    end

    // Input item latch.
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            item_reg <= in_item;
            op_reg   <= in_op;
        end
    end

    // Queue pointers, scan counters and sequence number.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            seq_reg   <= '0;
            r_reg     <= '0;
            w_reg     <= '0;
        end else begin
            if (cmd.scan_clr) begin
                r_reg <= '0;
                w_reg <= '0;
            end else begin
                if (cmd.rd_sel == RD_SCAN) begin
                    r_reg <= r_reg + CW'(1);
                end
                if (cmd.wr_cmp) begin
                    w_reg <= w_reg + CW'(1);
                end
            end
            if (cmd.compact_done) begin
                count_reg <= w_reg;
            end else if (cmd.head_pop) begin
                head_reg  <= head_reg + AW'(1);
                count_reg <= count_reg - CW'(1);
            end else if (cmd.count_dec) begin
                count_reg <= count_reg - CW'(1);
            end else if (cmd.store) begin
                count_reg <= count_reg + CW'(1);
                seq_reg   <= seq_reg + SEQ_BITS'(1);
            end
        end
    end

    // Output register, held until the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_found || cmd.out_empty) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_found) begin
            m_found_reg <= 1'b1;
            m_rec_reg   <= rd_q_reg;
        end else if (cmd.out_empty) begin
            m_found_reg <= 1'b0;
            m_rec_reg   <= '0;
        end
    end

    // Effective capacity, clamped to the range one to DEPTH.
    assign cap_ext = KW'(capacity);
    always_comb begin
        if (capacity == 5'd0) begin
            cap_eff = KW'(1);
        end else if (cap_ext > KW'(DEPTH)) begin
            cap_eff = KW'(DEPTH);
        end else begin
            cap_eff = cap_ext;
        end
    end

    // Status back to the controller.
    always_comb begin
        sts.is_take    = (op_reg == OP_TAKE);
        sts.count_zero = (count_reg == '0);
        sts.drop       = (item_reg[T-1:0] == '0) && (item_reg[T+3:T+1] != focus_kind);
        sts.dup        = (rd_q_reg[T-1:0]       == item_reg[T-1:0])
                      && (rd_q_reg[T+3:T]       == item_reg[T+3:T])
                      && (rd_q_reg[3*T+3:2*T+4] == item_reg[3*T+3:2*T+4])
                      && (rd_q_reg[IW-1:3*T+7]  == item_reg[IW-1:3*T+7]);
        sts.item_prio  = item_reg[T];
        sts.rd_prio    = rd_q_reg[T];
        sts.r_end      = (r_reg == count_reg);
        sts.full       = (KW'(count_reg) >= cap_eff);
        sts.out_busy   = m_valid_reg && !m_tready;
    end

    assign m_valid   = m_valid_reg;
    assign m_found   = m_found_reg;
    assign m_rec     = m_rec_reg;
    assign occupancy = count_reg;

endmodule

// ----- rtl/paq_ctrl.sv -----
module paq_ctrl import paq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Sequencing of take, drop, duplicate check, compaction, eviction and store.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.is_take) begin
                    if (!sts.count_zero) begin
                        cmd.rd_sel = RD_HEAD;
                        state_next = ST_TAKE_OUT;
                    end else if (!sts.out_busy) begin
                        cmd.out_empty = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (sts.drop) begin
                    state_next = ST_IDLE;
                end else if (!sts.count_zero) begin
                    cmd.rd_sel = RD_LAST;
                    state_next = ST_DUP_CHK;
                end else begin
                    cmd.scan_clr = 1'b1;
                    state_next   = sts.item_prio ? ST_CMP_RD : ST_EV_CHK;
                end
            end
            ST_TAKE_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_found = 1'b1;
                    cmd.head_pop  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DUP_CHK: begin
                if (sts.dup) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.scan_clr = 1'b1;
                    state_next   = sts.item_prio ? ST_CMP_RD : ST_EV_CHK;
                end
            end
            ST_CMP_RD: begin
                if (sts.r_end) begin
                    cmd.compact_done = 1'b1;
                    state_next       = ST_EV_CHK;
                end else begin
                    cmd.rd_sel = RD_SCAN;
                    state_next = ST_CMP_WR;
                end
            end
            ST_CMP_WR: begin
                cmd.wr_cmp = sts.rd_prio;
                state_next = ST_CMP_RD;
            end
            ST_EV_CHK: begin
                if (sts.full) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_EV_RD;
                end else begin
                    cmd.store  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EV_RD: begin
                if (sts.r_end) begin
                    cmd.head_pop = 1'b1;
                    state_next   = ST_EV_CHK;
                end else begin
                    cmd.rd_sel = RD_SCAN;
                    state_next = ST_EV_TST;
                end
            end
            ST_EV_TST: begin
                state_next = sts.rd_prio ? ST_EV_RD : ST_SH_RD;
            end
            ST_SH_RD: begin
                if (sts.r_end) begin
                    cmd.count_dec = 1'b1;
                    state_next    = ST_EV_CHK;
                end else begin
                    cmd.rd_sel = RD_SCAN;
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                cmd.wr_shift = 1'b1;
                state_next   = ST_SH_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/priority_announcement_queue_unit.sv -----
// Priority announcement queue: one item at a time through a controller and a record memory.
// A take reads the head record and presents it, or an all-zero record when the queue is empty,
// and waits while the output beat is still stalled; the input is held until it is done.
// A push is dropped, rejected as a duplicate of the last record or stored; an assertive push
// first compacts the queue to its assertive records, and a full queue evicts the first
// non-assertive record (shifting the later ones down) or else the head before the store.
// Reset (aresetn low at a clock edge) empties the queue, zeroes the sequence number
// and sets capacity to 16 and the focus kind to 1; record slots are not cleared.
`include "assert_macros.svh"

module priority_announcement_queue_unit import paq_pkg::*; #(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // text, priority_req, kind, bounds_tag, range_tag, control, checked, value_tag
    input  logic [((4*TAG_BITS+9+7)/8)*8-1:0]        s_tdata,
    // op
    input  logic                                     s_tuser,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // out_text, out_priority, out_kind, out_bounds, out_range, out_control,
    // out_checked, out_value, out_sequence
    output logic [((4*TAG_BITS+9+SEQ_BITS+7)/8)*8-1:0] m_tdata,
    // found
    output logic                                     m_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    input  logic                                     cfg_we,
    input  logic                                     cfg_index,
    input  logic [4:0]                               cfg_wdata
);

    localparam int IW   = 4 * TAG_BITS + 9;
    localparam int RW   = IW + SEQ_BITS;
    localparam int M_DW = ((RW + 7) / 8) * 8;

    logic [4:0]                   capacity_reg;
    logic [2:0]                   focus_reg;
    cmd_t                         cmd;
    sts_t                         sts;
    logic [RW-1:0]                m_rec;
    logic [$clog2(DEPTH+1)-1:0]   occupancy;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= 5'd16;
            focus_reg    <= 3'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CAPACITY: capacity_reg <= cfg_wdata;
                CFG_FOCUS:    focus_reg    <= cfg_wdata[2:0];
                default:      capacity_reg <= capacity_reg;
            endcase
        end
    end

    paq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    paq_datapath #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser),
        .in_item    (s_tdata[IW-1:0]),
        .capacity   (capacity_reg),
        .focus_kind (focus_reg),
        .m_tready   (m_tready),
        .m_valid    (m_tvalid),
        .m_found    (m_tuser),
        .m_rec      (m_rec),
        .occupancy  (occupancy)
    );

    assign m_tdata = M_DW'(m_rec);

    // The queue never holds more records than it has slots.
    `ASSERT_CLK(a_occ_bound, aclk, aresetn, occupancy <= ($clog2(DEPTH+1))'(DEPTH), "occupancy beyond depth")
    // Only one item is worked on at a time.
    `ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second item accepted while busy")
    // An empty take carries an all-zero record.
    `ASSERT_CLK(a_empty_zero, aclk, aresetn, !(m_tvalid && !m_tuser) || (m_tdata == '0), "empty take with data")
    // The queue only changes while an item is being processed.
    `ASSERT_NEXT(a_occ_idle, aclk, aresetn, s_tready && !s_tvalid, $stable(occupancy), "occupancy changed while idle")

endmodule
